// File: design/arenc_pkg.sv
// ----------------------------------------------------------------------------
// arenc_pkg: shared constants for the arithmetic encoder
// Command codes, frequency-table format and default sizes used by the
// encoder and by its port checker.
// ----------------------------------------------------------------------------
package arenc_pkg;

   // default sizes handed to the top level
   localparam int PRECISION_BITS_DEF = 31;
   localparam int SYMBOL_COUNT_DEF   = 128;
   localparam int FOLLOW_WIDTH_DEF   = 16;

   // frequency format: totals are scaled to 2^30
   localparam int FREQ_W     = 31;
   localparam int FREQ_SHIFT = 30;
   localparam logic [FREQ_W-1:0] FREQ_TOTAL = FREQ_W'(1) << FREQ_SHIFT;

   // operand width of the shared multiplier (one slice of a frequency bound)
   localparam int MUL_OP_W = 16;

   // command codes
   localparam int FUNC_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

endpackage

// File: design/arithmetic_encoder.sv
// Sequence: load reads the table, then writes; encode narrows the interval
// (two table reads, the multiplier steps, one update), rescales at most
// PRECISION_BITS-1 times, ends on a closing check and waits on stalled results;
// finish waits for a free result. One beat at a time; the shared 16-bit-slice
// multiplier and the rescale loop, one step per cycle unless stalled, set the rate.
// Reset (synchronous): interval set to [0, WHOLE]; pending count and all table valid bits clear.
// ----------------------------------------------------------------------------
// arithmetic_encoder: static-model multi-symbol arithmetic encoder
// Builds a cumulative frequency table from load beats, narrows the coding
// interval on encode beats with a shared partial-product multiplier and
// emits one result beat per E1/E2 rescale; finish flushes the coder.
// ----------------------------------------------------------------------------
module arithmetic_encoder #(
   parameter int PRECISION_BITS = arenc_pkg::PRECISION_BITS_DEF,
   parameter int SYMBOL_COUNT   = arenc_pkg::SYMBOL_COUNT_DEF,
   parameter int FOLLOW_WIDTH   = arenc_pkg::FOLLOW_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [arenc_pkg::FUNC_W-1:0]      req_func,
   input  logic [$clog2(SYMBOL_COUNT)-1:0]   req_symbol,
   input  logic [arenc_pkg::FREQ_W-1:0]      req_frequency,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_lead_bit,
   output logic [FOLLOW_WIDTH-1:0]           rsp_follow_count,
   output logic                              rsp_last
);
   import arenc_pkg::*;

   localparam int SYM_W = $clog2(SYMBOL_COUNT);
   localparam int P     = PRECISION_BITS;
   localparam int PROD_W = P + MUL_OP_W;
   localparam int ACC_W  = P + 2 * MUL_OP_W;
   localparam int BUD_W  = $clog2(P);
   localparam logic [BUD_W-1:0] RESCALE_BUDGET = BUD_W'(P - 1);
   localparam logic [P-1:0] WHOLE   = P'(1) << (P - 1);
   localparam logic [P-1:0] HALF    = WHOLE >> 1;
   localparam logic [P-1:0] QUART   = WHOLE >> 2;
   localparam logic [P-1:0] THREE_Q = HALF + QUART;
   localparam logic [FOLLOW_WIDTH-1:0] FOLLOW_MAX = '1;
   localparam logic [2:0] MUL_LAST = 3'd4;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_LD_RD  = 9'b000000010,
      ST_LD_WR  = 9'b000000100,
      ST_RD_LO  = 9'b000001000,
      ST_RD_HI  = 9'b000010000,
      ST_MUL    = 9'b000100000,
      ST_NARROW = 9'b001000000,
      ST_SCALE  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [SYM_W-1:0]        sym_ff, sym_in;
   logic [FREQ_W-1:0]       freq_ff, freq_in;
   logic [P-1:0]            low_ff, low_in;
   logic [P-1:0]            high_ff, high_in;
   logic [FOLLOW_WIDTH-1:0] pend_ff, pend_in;
   logic [P-1:0]            w_ff, w_in;
   logic [FREQ_W-1:0]       clo_ff, clo_in;
   logic [FREQ_W-1:0]       chi_ff, chi_in;
   logic [2:0]              mcnt_ff, mcnt_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [ACC_W-1:0]        acc_lo_ff, acc_lo_in;
   logic [ACC_W-1:0]        acc_hi_ff, acc_hi_in;
   logic [BUD_W-1:0]        budget_ff, budget_in;
   logic                    e3_phase_ff, e3_phase_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_lead_ff, rsp_lead_in;
   logic [FOLLOW_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   // table memory with one registered read port and one write port
   logic [FREQ_W-1:0]       tbl_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] tbl_vld_ff;
   logic [FREQ_W-1:0]       rd_data_ff;
   logic                    rd_vld_ff;
   logic [SYM_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [SYM_W-1:0]        wr_addr;
   logic [FREQ_W-1:0]       wr_data;

   // helpers
   logic [SYM_W:0]          sym_nxt;
   logic                    nxt_ok;
   logic                    req_sym_ok;
   logic [FREQ_W-1:0]       rd_entry;
   logic [FREQ_W-1:0]       entry_sat;
   logic [FREQ_W:0]         ld_sum;
   logic [FREQ_W-1:0]       ld_sat;
   logic [FREQ_W-1:0]       chi_raw;
   logic [MUL_OP_W-1:0]     mul_op;
   logic                    out_free;
   logic                    e1, e2, e3;
   logic [P-1:0]            lo12, hi12, lo3, hi3;
   logic                    more12;

   // port drive
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lead_bit     = rsp_lead_ff;
   assign rsp_follow_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   // symbol range and table read data
   assign sym_nxt    = {1'b0, sym_ff} + (SYM_W+1)'(1);
   assign nxt_ok     = sym_nxt < (SYM_W+1)'(SYMBOL_COUNT);
   assign req_sym_ok = {1'b0, req_symbol} < (SYM_W+1)'(SYMBOL_COUNT);
   assign rd_entry   = rd_vld_ff ? rd_data_ff : '0;
   assign entry_sat  = (rd_entry > FREQ_TOTAL) ? FREQ_TOTAL : rd_entry;
   assign ld_sum     = {1'b0, rd_entry} + {1'b0, freq_ff};
   assign ld_sat     = (ld_sum > {1'b0, FREQ_TOTAL}) ? FREQ_TOTAL : ld_sum[FREQ_W-1:0];
   assign chi_raw    = nxt_ok ? entry_sat : FREQ_TOTAL;

   // pick the multiplier slice for each step
   always_comb begin
      case (mcnt_ff)
         3'd0:    mul_op = clo_ff[MUL_OP_W-1:0];
         3'd1:    mul_op = MUL_OP_W'(clo_ff >> MUL_OP_W);
         3'd2:    mul_op = chi_ff[MUL_OP_W-1:0];
         3'd3:    mul_op = MUL_OP_W'(chi_ff >> MUL_OP_W);
         default: mul_op = '0;
      endcase
   end

   // rescale conditions and candidate next intervals
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign e1       = high_ff < HALF;
   assign e2       = low_ff > HALF;
   assign e3       = (low_ff > QUART) && (high_ff < THREE_Q);
   assign lo12     = e1 ? (low_ff << 1)  : ((low_ff - HALF) << 1);
   assign hi12     = e1 ? (high_ff << 1) : ((high_ff - HALF) << 1);
   assign lo3      = (low_ff - QUART) << 1;
   assign hi3      = (high_ff - QUART) << 1;
   assign more12   = (budget_ff != BUD_W'(1)) && ((hi12 < HALF) || (lo12 > HALF));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sym_in       = sym_ff;
      freq_in      = freq_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      pend_in      = pend_ff;
      w_in         = w_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      mcnt_in      = mcnt_ff;
      prod_in      = prod_ff;
      acc_lo_in    = acc_lo_ff;
      acc_hi_in    = acc_hi_ff;
      budget_in    = budget_ff;
      e3_phase_in  = e3_phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_lead_in  = rsp_lead_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rd_addr      = sym_ff;
      wr_en        = 1'b0;
      wr_addr      = sym_nxt[SYM_W-1:0];
      wr_data      = ld_sat;

      case (state_ff)
         ST_IDLE: begin
            // take a beat and dispatch on its command
            if (req_valid) begin
               sym_in  = req_symbol;
               freq_in = req_frequency;
               case (req_func)
                  FUNC_LOAD:   state_in = ST_LD_RD;
                  FUNC_ENCODE: state_in = req_sym_ok ? ST_RD_LO : ST_IDLE;
                  FUNC_FINISH: state_in = ST_FINISH;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_RD: begin
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            // the top symbol's bound is fixed, so drop its load
            wr_en    = nxt_ok;
            state_in = ST_IDLE;
         end
         ST_RD_LO: begin
            w_in     = high_ff - low_ff;
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            clo_in   = entry_sat;
            rd_addr  = sym_nxt[SYM_W-1:0];
            mcnt_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // one slice product a cycle, accumulated in the cycle after from the product register
            if (mcnt_ff == 3'd0) begin
               chi_in = (chi_raw < clo_ff) ? clo_ff : chi_raw;
            end
            prod_in = PROD_W'(w_ff) * PROD_W'(mul_op);
            mcnt_in = mcnt_ff + 3'd1;
            case (mcnt_ff)
               3'd1:    acc_lo_in = ACC_W'(prod_ff);
               3'd2:    acc_lo_in = acc_lo_ff + (ACC_W'(prod_ff) << MUL_OP_W);
               3'd3:    acc_hi_in = ACC_W'(prod_ff);
               3'd4:    acc_hi_in = acc_hi_ff + (ACC_W'(prod_ff) << MUL_OP_W);
               default: acc_lo_in = acc_lo_ff;
            endcase
            if (mcnt_ff == MUL_LAST) begin
               state_in = ST_NARROW;
            end
         end
         ST_NARROW: begin
            high_in     = low_ff + acc_hi_ff[FREQ_SHIFT +: P];
            low_in      = low_ff + acc_lo_ff[FREQ_SHIFT +: P];
            budget_in   = RESCALE_BUDGET;
            e3_phase_in = 1'b0;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            // one rescale a cycle, E1/E2 only while the result is free; E1/E2 emit a beat, E3 counts pending bits
            if (budget_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!e3_phase_ff && (e1 || e2)) begin
               if (out_free) begin
                  low_in       = lo12;
                  high_in      = hi12;
                  rsp_valid_in = 1'b1;
                  rsp_lead_in  = !e1;
                  rsp_count_in = pend_ff;
                  rsp_last_in  = !more12;
                  pend_in      = '0;
                  budget_in    = budget_ff - BUD_W'(1);
               end
            end else if (e3) begin
               low_in      = lo3;
               high_in     = hi3;
               e3_phase_in = 1'b1;
               pend_in     = (pend_ff < FOLLOW_MAX) ? pend_ff + FOLLOW_WIDTH'(1) : pend_ff;
               budget_in   = budget_ff - BUD_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            // emit the closing beat, then return the coder to its start
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lead_in  = low_ff > QUART;
               rsp_count_in = (pend_ff < FOLLOW_MAX) ? pend_ff + FOLLOW_WIDTH'(1) : FOLLOW_MAX;
               rsp_last_in  = 1'b1;
               low_in       = '0;
               high_in      = WHOLE;
               pend_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and coder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= '0;
         high_ff      <= WHOLE;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         tbl_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            tbl_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      freq_ff      <= freq_in;
      w_ff         <= w_in;
      clo_ff       <= clo_in;
      chi_ff       <= chi_in;
      mcnt_ff      <= mcnt_in;
      prod_ff      <= prod_in;
      acc_lo_ff    <= acc_lo_in;
      acc_hi_ff    <= acc_hi_in;
      budget_ff    <= budget_in;
      e3_phase_ff  <= e3_phase_in;
      rsp_lead_ff  <= rsp_lead_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tbl_mem[rd_addr];
      rd_vld_ff  <= tbl_vld_ff[rd_addr];
   end

endmodule

// File: design/arenc_check.sv
// ----------------------------------------------------------------------------
// arenc_check: port-level checks for the arithmetic encoder
// Watches the request and result channels and flags ordering slips.
// ----------------------------------------------------------------------------
module arenc_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [arenc_pkg::FUNC_W-1:0] req_func,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_lead_bit,
   input logic                         rsp_last
);
   import arenc_pkg::*;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lead_bit) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // a load never produces a result beat
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_func == FUNC_LOAD) |=> !$rose(rsp_valid))
      else $error("result beat raised after a load");

   // the block is busy right after taking a finish beat
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_func == FUNC_FINISH) |=> req_stall)
      else $error("request taken while finish pending");

   // finish emits a closing beat as soon as the result register is free
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_func == FUNC_FINISH) ##1 (!rsp_valid || !rsp_stall)
      |=> rsp_valid && rsp_last)
      else $error("finish did not emit a final beat");

endmodule

bind arithmetic_encoder arenc_check u_arenc_check (.*);
